FILE: sv/pht_pkg.sv
// Package with the word types, constants and helper functions of the pose transform block.
`timescale 1ns / 1ps
package pht_pkg;

	typedef logic signed [15:0] q14_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
	} pose_t;

	typedef struct packed {
		q14_t r00;
		q14_t r01;
		q14_t r02;
		q14_t r10;
		q14_t r11;
		q14_t r12;
		q14_t r20;
		q14_t r21;
		q14_t r22;
		logic signed [31:0] t_x;
		logic signed [31:0] t_y;
		logic signed [31:0] t_z;
	} xform_t;

	localparam int SC_LAT = 19;
	localparam int NUM_TERMS = 5;
	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
	localparam logic [32:0] HALF_Q30 = 33'd1686629713;
	localparam logic [31:0] ONE_Q30 = 32'd1073741824;
	localparam logic [47:0] ONE_Q14 = 48'd16384;

	function automatic logic [31:0] sin_div(input int i);
		logic [31:0] k;
		case (i)
			0: k = 32'd110;
			1: k = 32'd72;
			2: k = 32'd42;
			3: k = 32'd20;
			default: k = 32'd6;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] cos_div(input int i);
		logic [31:0] k;
		case (i)
			0: k = 32'd132;
			1: k = 32'd90;
			2: k = 32'd56;
			3: k = 32'd30;
			default: k = 32'd12;
		endcase
		return k;
	endfunction

	function automatic q14_t round_sat(input logic signed [47:0] v, input int sh);
		logic neg;
		logic [47:0] m;
		q14_t r;
		neg = v[47];
		m = neg ? 48'(-v) : 48'(v);
		m = (m + (48'd1 << (sh - 1))) >> sh;
		if (m > ONE_Q14) begin
			m = ONE_Q14;
		end
		r = signed'(m[15:0]);
		return neg ? -r : r;
	endfunction

endpackage

FILE: sv/pose_to_homogeneous_transform.sv
// Top level of the pose to homogeneous transform block (Z-Y-X rotation plus translation).
//
// A pose word enters on pose / pose_valid / pose_stall and the top three rows of its
// 4x4 transform leave on xform / xform_valid / xform_stall. A word is taken at a rising
// edge where valid is high and stall is low. Angles are Q3.13 radians, positions Q16.16,
// rotation entries Q1.14 saturated to plus or minus one; the translation passes through.
// Throughput is one pose per cycle unless the output stalls: each of the three angles runs
// through its own 19-stage sine/cosine pipeline (two input stages, five series terms of
// three stages each and two final stages), followed by two product stages and the output
// register.
// Reset clears the valid bits of every stage and drops any words in flight.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// pose_stall is raised in the same cycle, so no word is lost or repeated.
`timescale 1ns / 1ps
module pose_to_homogeneous_transform import pht_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pose_valid,
	output logic   pose_stall,
	input  pose_t  pose,
	output logic   xform_valid,
	input  logic   xform_stall,
	output xform_t xform
);

	localparam int LAT = SC_LAT + 3;

	logic en;
	logic [LAT-1:0] vld_q;

	assign pose_stall = vld_q[LAT-1] && xform_stall;
	assign en = !pose_stall;
	assign xform_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pose_valid};
		end
	end

	logic [95:0] pos_q [LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			pos_q[0] <= {pose.pos_x, pose.pos_y, pose.pos_z};
			for (int k = 1; k < LAT - 1; k++) begin
				pos_q[k] <= pos_q[k-1];
			end
		end
	end

	q14_t sy;
	q14_t cy;
	q14_t sp;
	q14_t cp;
	q14_t sr;
	q14_t cr;

	pht_sincos u_yaw (.clk(clk), .en(en), .angle(pose.yaw_angle), .sin_val(sy), .cos_val(cy));
	pht_sincos u_pitch (.clk(clk), .en(en), .angle(pose.pitch_angle), .sin_val(sp),
		.cos_val(cp));
	pht_sincos u_roll (.clk(clk), .en(en), .angle(pose.roll_angle), .sin_val(sr),
		.cos_val(cr));

	logic signed [31:0] cy_sp_s1, sy_sp_s1, cy_cr_s1, sy_cr_s1, cy_sr_s1, sy_sr_s1;
	logic signed [31:0] cy_cp_s1, sy_cp_s1, cp_sr_s1, cp_cr_s1;
	q14_t sr_s1;
	q14_t cr_s1;
	q14_t nsp_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cy_sp_s1 <= cy * sp;
			sy_sp_s1 <= sy * sp;
			cy_cr_s1 <= cy * cr;
			sy_cr_s1 <= sy * cr;
			cy_sr_s1 <= cy * sr;
			sy_sr_s1 <= sy * sr;
			cy_cp_s1 <= cy * cp;
			sy_cp_s1 <= sy * cp;
			cp_sr_s1 <= cp * sr;
			cp_cr_s1 <= cp * cr;
			sr_s1 <= sr;
			cr_s1 <= cr;
			nsp_s1 <= -sp;
		end
	end

	logic signed [47:0] t01_s2, t02_s2, t11_s2, t12_s2;
	logic signed [31:0] cy_cp_s2, sy_cp_s2, cp_sr_s2, cp_cr_s2;
	q14_t nsp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t01_s2 <= 48'(cy_sp_s1) * 48'(sr_s1) - (48'(sy_cr_s1) <<< 14);
			t02_s2 <= 48'(cy_sp_s1) * 48'(cr_s1) + (48'(sy_sr_s1) <<< 14);
			t11_s2 <= 48'(sy_sp_s1) * 48'(sr_s1) + (48'(cy_cr_s1) <<< 14);
			t12_s2 <= 48'(sy_sp_s1) * 48'(cr_s1) - (48'(cy_sr_s1) <<< 14);
			cy_cp_s2 <= cy_cp_s1;
			sy_cp_s2 <= sy_cp_s1;
			cp_sr_s2 <= cp_sr_s1;
			cp_cr_s2 <= cp_cr_s1;
			nsp_s2 <= nsp_s1;
		end
	end

	xform_t out_q;

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.r00 <= round_sat(48'(cy_cp_s2), 14);
			out_q.r01 <= round_sat(t01_s2, 28);
			out_q.r02 <= round_sat(t02_s2, 28);
			out_q.r10 <= round_sat(48'(sy_cp_s2), 14);
			out_q.r11 <= round_sat(t11_s2, 28);
			out_q.r12 <= round_sat(t12_s2, 28);
			out_q.r20 <= nsp_s2;
			out_q.r21 <= round_sat(48'(cp_sr_s2), 14);
			out_q.r22 <= round_sat(48'(cp_cr_s2), 14);
			out_q.t_x <= signed'(pos_q[LAT-2][95:64]);
			out_q.t_y <= signed'(pos_q[LAT-2][63:32]);
			out_q.t_z <= signed'(pos_q[LAT-2][31:0]);
		end
	end

	assign xform = out_q;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		xform_valid && xform_stall |=> xform_valid && $stable(xform))
		else $error("Stalled result word changed or vanished.");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pose_stall |-> xform_valid)
		else $error("Input stalled without a waiting result word.");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		xform_valid |-> xform.r00 <= 16384 && xform.r00 >= -16384
			&& xform.r11 <= 16384 && xform.r11 >= -16384)
		else $error("Rotation entry outside unit range.");
`endif

endmodule

FILE: sv/pht_sincos.sv
// Pipelined fixed-point sine and cosine of one Q3.13 angle, giving Q1.14 results.
`timescale 1ns / 1ps
module pht_sincos import pht_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic signed [15:0] angle,
	output q14_t              sin_val,
	output q14_t              cos_val
);

	logic [15:0] mag;
	logic [32:0] ur;
	logic signed [33:0] w;
	logic [30:0] u_n;
	logic ns_n;
	logic nc_n;

	always_comb begin
		mag = angle[15] ? 16'(-angle) : 16'(angle);
		ur = {mag, 17'b0};
		ns_n = angle[15];
		nc_n = 1'b0;
		w = PI_Q30 - signed'({1'b0, ur});
		u_n = ur[30:0];
		if (ur > HALF_Q30) begin
			nc_n = 1'b1;
			if (w < 0) begin
				w = -w;
				ns_n = !ns_n;
			end
			u_n = w[30:0];
		end
	end

	logic [30:0] u_s1;
	logic [1:0] fl_s1;
	logic [30:0] u_s2;
	logic [31:0] u2_s2;
	logic [1:0] fl_s2;
	logic [61:0] uu;

	assign uu = 62'(u_s1) * 62'(u_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u_n;
			fl_s1 <= {ns_n, nc_n};
			u_s2 <= u_s1;
			u2_s2 <= uu[61:30];
			fl_s2 <= fl_s1;
		end
	end

	logic [30:0] st_u [NUM_TERMS+1];
	logic [31:0] st_u2 [NUM_TERMS+1];
	logic [1:0] st_fl [NUM_TERMS+1];
	logic [30:0] st_ts [NUM_TERMS+1];
	logic [30:0] st_tc [NUM_TERMS+1];

	assign st_u[0] = u_s2;
	assign st_u2[0] = u2_s2;
	assign st_fl[0] = fl_s2;
	assign st_ts[0] = ONE_Q30[30:0];
	assign st_tc[0] = ONE_Q30[30:0];

	for (genvar i = 0; i < NUM_TERMS; i++) begin : g_term
		localparam logic [31:0] KS = sin_div(i);
		localparam logic [31:0] KC = cos_div(i);
		localparam logic [31:0] MS = 32'((64'd1 << 32) / KS);
		localparam logic [31:0] MC = 32'((64'd1 << 32) / KC);

		logic [62:0] pas;
		logic [62:0] pac;
		logic [30:0] u_sa;
		logic [31:0] u2_sa;
		logic [1:0] fl_sa;
		logic [31:0] qs_sa;
		logic [31:0] qc_sa;

		assign pas = 63'(st_u2[i]) * 63'(st_ts[i]);
		assign pac = 63'(st_u2[i]) * 63'(st_tc[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				u_sa <= st_u[i];
				u2_sa <= st_u2[i];
				fl_sa <= st_fl[i];
				qs_sa <= pas[61:30];
				qc_sa <= pac[61:30];
			end
		end

		logic [63:0] pbs;
		logic [63:0] pbc;
		logic [30:0] u_sb;
		logic [31:0] u2_sb;
		logic [1:0] fl_sb;
		logic [31:0] qs_sb;
		logic [31:0] qc_sb;
		logic [31:0] es_sb;
		logic [31:0] ec_sb;

		assign pbs = 64'(qs_sa) * 64'(MS);
		assign pbc = 64'(qc_sa) * 64'(MC);

		always_ff @(posedge clk) begin
			if (en) begin
				u_sb <= u_sa;
				u2_sb <= u2_sa;
				fl_sb <= fl_sa;
				qs_sb <= qs_sa;
				qc_sb <= qc_sa;
				es_sb <= pbs[63:32];
				ec_sb <= pbc[63:32];
			end
		end

		logic [31:0] rs;
		logic [31:0] rc;
		logic [31:0] es_fix;
		logic [31:0] ec_fix;
		logic [31:0] ts_n;
		logic [31:0] tc_n;
		logic [30:0] u_sc;
		logic [31:0] u2_sc;
		logic [1:0] fl_sc;
		logic [30:0] ts_sc;
		logic [30:0] tc_sc;

		always_comb begin
			rs = qs_sb - 32'(es_sb * KS);
			rc = qc_sb - 32'(ec_sb * KC);
			es_fix = (rs >= KS) ? es_sb + 32'd1 : es_sb;
			ec_fix = (rc >= KC) ? ec_sb + 32'd1 : ec_sb;
			ts_n = ONE_Q30 - es_fix;
			tc_n = ONE_Q30 - ec_fix;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				u_sc <= u_sb;
				u2_sc <= u2_sb;
				fl_sc <= fl_sb;
				ts_sc <= ts_n[30:0];
				tc_sc <= tc_n[30:0];
			end
		end

		assign st_u[i+1] = u_sc;
		assign st_u2[i+1] = u2_sc;
		assign st_fl[i+1] = fl_sc;
		assign st_ts[i+1] = ts_sc;
		assign st_tc[i+1] = tc_sc;
	end

	logic [61:0] pfs;
	logic [62:0] pfc;
	logic [30:0] s_f1;
	logic [31:0] pc_f1;
	logic [1:0] fl_f1;

	assign pfs = 62'(st_u[NUM_TERMS]) * 62'(st_ts[NUM_TERMS]);
	assign pfc = 63'(st_u2[NUM_TERMS]) * 63'(st_tc[NUM_TERMS]);

	always_ff @(posedge clk) begin
		if (en) begin
			s_f1 <= pfs[60:30];
			pc_f1 <= pfc[61:30];
			fl_f1 <= st_fl[NUM_TERMS];
		end
	end

	logic signed [47:0] s_sgn;
	logic signed [47:0] c_sgn;
	q14_t s_f2;
	q14_t c_f2;

	always_comb begin
		s_sgn = signed'({17'b0, s_f1});
		c_sgn = signed'({16'b0, ONE_Q30}) - signed'({17'b0, pc_f1[31:1]});
		if (fl_f1[1]) begin
			s_sgn = -s_sgn;
		end
		if (fl_f1[0]) begin
			c_sgn = -c_sgn;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_f2 <= round_sat(s_sgn, 16);
			c_f2 <= round_sat(c_sgn, 16);
		end
	end

	assign sin_val = s_f2;
	assign cos_val = c_f2;

endmodule
